// ===== hdl/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and the CORDIC arctangent table for the
// differential-drive odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int TICK_WIDTH_DEF   = 16;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_TICK_DISTANCE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADING_GAIN  = 8'd1;

  // CORDIC working width: Q2.30 vector plus guard bits
  localparam int CW = 34;
  localparam logic [CW-1:0] CORDIC_INIT = 34'd652032874;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_D,
    S_MUL_T,
    S_ANGLE,
    S_CORDIC,
    S_MXL,
    S_MXH,
    S_MYL,
    S_MYH,
    S_AY1,
    S_AY2,
    S_DONE
  } state_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/differential_drive_odometry_top.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_top
// Dead-reckoning pose update for a differential-drive base.
// ----------------------------------------------------------------------------
// Each input transaction carries signed left and right encoder tick deltas and
// returns one result transaction with the updated x, y (signed Q16.16 metres,
// saturating) and heading (binary angle, 2^32 per turn). An item occupies the
// block from acceptance until its result is registered, and no new item is
// accepted meanwhile: one iterative CORDIC unit takes most of that time, and
// one shared multiplier runs six products in turn around it. A finished result
// sits in an output register, so the next item may be accepted while it waits.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_top #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF,
  parameter int TICK_WIDTH   = odo_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [odo_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [odo_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [TICK_WIDTH-1:0]     left_ticks,
  input  wire logic signed [TICK_WIDTH-1:0]     right_ticks,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [31:0]                    pos_x,
  output logic signed [31:0]                    pos_y,
  output logic [31:0]                           heading
);
  import odo_pkg::*;

  localparam int MW  = TICK_WIDTH + 1;
  localparam int A_W = (MW > 24) ? MW : 24;
  localparam int PW  = A_W + 32;

  state_t state, state_next;

  logic [31:0] tick_distance, heading_gain;
  logic signed [31:0] x_acc, y_acc;
  logic [31:0] angle_acc;

  logic [MW-1:0] smag, tmag;
  logic          dneg, tneg, flip;
  logic [47:0]   travel;
  logic [31:0]   cxm, cym;
  logic          xneg, yneg;
  logic [55:0]   plo;
  logic [49:0]   mag;

  logic [A_W-1:0] mul_a;
  logic [31:0]    mul_b;
  logic [PW-1:0]  mul_p;

  logic cordic_start, cordic_done;
  logic signed [CW-1:0] cordic_z, cordic_x, cordic_y;

  // input magnitudes
  logic signed [MW-1:0] sum_s, diff_s;
  always_comb begin
    sum_s  = MW'(left_ticks) + MW'(right_ticks);
    diff_s = MW'(right_ticks) - MW'(left_ticks);
  end

  // distance and turn rounding
  logic [PW:0]  dsum;
  logic [41:0]  tsum, hsum;
  logic [31:0]  turn, half, mid, mid_f;
  logic         flip_c;
  always_comb begin
    dsum   = (PW+1)'(mul_p) + (PW+1)'(17'h10000);
    tsum   = {1'b0, mul_p[40:0]} + 42'd128;
    hsum   = {1'b0, mul_p[40:0]} + 42'd256;
    turn   = tneg ? (32'd0 - tsum[39:8]) : tsum[39:8];
    half   = tneg ? (32'd0 - hsum[40:9]) : hsum[40:9];
    mid    = angle_acc + half;
    flip_c = mid[31] ^ mid[30];
    mid_f  = flip_c ? (mid + 32'h80000000) : mid;
    cordic_z = $signed(CW'($signed(mid_f)));
  end

  // CORDIC result magnitudes
  logic signed [CW-1:0] fx, fy, ax, ay;
  always_comb begin
    fx = flip ? -cordic_x : cordic_x;
    fy = flip ? -cordic_y : cordic_y;
    ax = fx[CW-1] ? -fx : fx;
    ay = fy[CW-1] ? -fy : fy;
  end

  // rounded magnitude of D * c / 2^30 from two 24-bit partial products
  logic [80:0] msum;
  always_comb begin
    msum = 81'(plo) + {1'b0, mul_p[55:0], 24'd0} + 81'h20000000;
  end

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic [49:0] m,
                                                 input logic neg);
    logic signed [51:0] d, s;
    d = neg ? -$signed(52'(m)) : $signed(52'(m));
    s = 52'(acc) + d;
    if (s > 52'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (s < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  odo_mul #(.A_W(A_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .z_in  (cordic_z),
    .done  (cordic_done),
    .cx    (cordic_x),
    .cy    (cordic_y)
  );

  logic in_accept, out_free;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_MUL_D;
      S_MUL_D:  state_next = S_MUL_T;
      S_MUL_T:  state_next = S_ANGLE;
      S_ANGLE:  state_next = S_CORDIC;
      S_CORDIC: if (cordic_done) state_next = S_MXL;
      S_MXL:    state_next = S_MXH;
      S_MXH:    state_next = S_MYL;
      S_MYL:    state_next = S_MYH;
      S_MYH:    state_next = S_AY1;
      S_AY1:    state_next = S_AY2;
      S_AY2:    state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = (state != S_IDLE);
    cordic_start = (state == S_ANGLE);
    mul_a        = A_W'(travel[23:0]);
    mul_b        = cxm;
    case (state)
      S_MUL_D: begin
        mul_a = A_W'(smag);
        mul_b = tick_distance;
      end
      S_MUL_T: begin
        mul_a = A_W'(tmag);
        mul_b = heading_gain;
      end
      S_MXL: begin
        mul_a = A_W'(travel[23:0]);
        mul_b = cxm;
      end
      S_MXH: begin
        mul_a = A_W'(travel[47:24]);
        mul_b = cxm;
      end
      S_MYL: begin
        mul_a = A_W'(travel[23:0]);
        mul_b = cym;
      end
      S_MYH: begin
        mul_a = A_W'(travel[47:24]);
        mul_b = cym;
      end
      default: begin
        mul_a = A_W'(travel[23:0]);
        mul_b = cxm;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tick_distance <= '0;
      heading_gain  <= '0;
      x_acc         <= '0;
      y_acc         <= '0;
      angle_acc     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICK_DISTANCE: tick_distance <= cfg_data;
          REG_HEADING_GAIN:  heading_gain  <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_ANGLE) angle_acc <= angle_acc + turn;
      if (state == S_MYH)   x_acc <= sat_add(x_acc, mag, dneg ^ xneg);
      if (state == S_AY2)   y_acc <= sat_add(y_acc, mag, dneg ^ yneg);
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      smag <= sum_s[MW-1]  ? MW'(-sum_s)  : MW'(sum_s);
      tmag <= diff_s[MW-1] ? MW'(-diff_s) : MW'(diff_s);
      dneg <= sum_s[MW-1];
      tneg <= diff_s[MW-1];
    end
    if (state == S_MUL_T) travel <= 48'(dsum >> 17);
    if (state == S_ANGLE) flip <= flip_c;
    if (state == S_CORDIC && cordic_done) begin
      cxm  <= ax[31:0];
      cym  <= ay[31:0];
      xneg <= fx[CW-1];
      yneg <= fy[CW-1];
    end
    if (state == S_MXH || state == S_MYH) plo <= mul_p[55:0];
    if (state == S_MYL || state == S_AY1) mag <= msum[79:30];
    if (state == S_DONE && out_free) begin
      pos_x   <= x_acc;
      pos_y   <= y_acc;
      heading <= angle_acc;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/odo_mul.sv =====
// ----------------------------------------------------------------------------
// odo_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_mul #(
  parameter int A_W = 24
) (
  input  wire logic             clk,
  input  wire logic [A_W-1:0]   a,
  input  wire logic [31:0]      b,
  output logic      [A_W+31:0]  p
);

  always_ff @(posedge clk) begin
    p <= (A_W+32)'(a) * (A_W+32)'(b);
  end

endmodule

`default_nettype wire

// ===== hdl/odo_cordic.sv =====
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_cordic #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [odo_pkg::CW-1:0] z_in,
  output logic                            done,
  output logic signed [odo_pkg::CW-1:0]   cx,
  output logic signed [odo_pkg::CW-1:0]   cy
);
  import odo_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);

  logic          running;
  logic [IW-1:0] step;
  logic signed [CW-1:0] z;

  logic signed [CW-1:0] xs, ys, at;
  logic signed [CW-1:0] cx_next, cy_next, z_next;
  logic last;

  always_comb begin
    xs   = cx >>> step;
    ys   = cy >>> step;
    at   = $signed(CW'(atan_entry(5'(step))));
    last = (step == IW'(CORDIC_STEPS - 1));
    if (!z[CW-1]) begin
      cx_next = cx - ys;
      cy_next = cy + xs;
      z_next  = z - at;
    end else begin
      cx_next = cx + ys;
      cy_next = cy - xs;
      z_next  = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cx <= $signed(CORDIC_INIT);
      cy <= '0;
      z  <= z_in;
    end else if (running) begin
      cx <= cx_next;
      cy <= cy_next;
      z  <= z_next;
    end
  end

endmodule

`default_nettype wire
